@@ rtl/core/bpmi_pkg.sv @@
// ----------------------------------------------------------------------------
// bpmi_pkg
// Shared types and constants for the binary polynomial modular inverse block.
// ----------------------------------------------------------------------------
package bpmi_pkg;

   // Polynomial degree bound: bits at and above POLY_BITS are ignored.
   localparam int POLY_BITS = 64;
   localparam int WORD_W    = 64;
   localparam int CNT_W     = $clog2(WORD_W + 1);   // holds degree + 1, 0 for zero
   localparam int SH_W      = $clog2(WORD_W);
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   localparam logic [WORD_W-1:0] POLY_MASK = {WORD_W{1'b1}} >> (WORD_W - POLY_BITS);

   // Register decode: one 64-bit register per 8-byte slot, so paddr[3] is the index.
   localparam logic REG_MODULUS = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NORM,
      ST_DIV,
      ST_RED,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic req_fire;
      logic b_zero;     // divisor degree count ran out: divisor is zero
      logic b_top;      // divisor bit under the count is set
      logic div_go;     // dividend bound still at or above divisor degree
      logic mod_zero;
      logic red_go;     // final reduction not yet below modulus degree
      logic out_free;
      logic first;      // first normalization: divisor is the modulus
   } stat_type;

   typedef struct packed {
      logic idle;
      logic start;
      logic norm_dec;
      logic set_km;
      logic div_step;
      logic swap;
      logic red_init;
      logic red_step;
      logic finish;
   } ctrl_type;

endpackage

@@ rtl/core/bpmi_shift_xor.sv @@
// ----------------------------------------------------------------------------
// bpmi_shift_xor
// Shared two-lane shift-xor unit: z = x ^ (y << shamt) on both lanes.
// ----------------------------------------------------------------------------
module bpmi_shift_xor (
   input  logic [bpmi_pkg::WORD_W-1:0] x0,
   input  logic [bpmi_pkg::WORD_W-1:0] y0,
   input  logic [bpmi_pkg::WORD_W-1:0] x1,
   input  logic [bpmi_pkg::WORD_W-1:0] y1,
   input  logic [bpmi_pkg::SH_W-1:0]   shamt,
   output logic [bpmi_pkg::WORD_W-1:0] z0,
   output logic [bpmi_pkg::WORD_W-1:0] z1
);
   import bpmi_pkg::*;

   // Lane 0 carries the remainder, lane 1 the Bezout coefficient.
   assign z0 = x0 ^ (y0 << shamt);
   assign z1 = x1 ^ (y1 << shamt);

endmodule

@@ rtl/core/bpmi_ctrl.sv @@
// ----------------------------------------------------------------------------
// bpmi_ctrl
// Sequencer for the Euclid loop: normalize, divide step, swap, final reduce.
// ----------------------------------------------------------------------------
module bpmi_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  bpmi_pkg::stat_type  stat,
   output bpmi_pkg::ctrl_type  ctrl
);
   import bpmi_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (stat.req_fire) state_in = ST_NORM;
         end
         ST_NORM: begin
            if (stat.b_zero) begin
               state_in = stat.mod_zero ? ST_DONE : ST_RED;
            end else if (stat.b_top) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!stat.div_go) state_in = ST_NORM;
         end
         ST_RED: begin
            if (!stat.red_go) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE: begin
            ctrl.idle  = 1'b1;
            ctrl.start = stat.req_fire;
         end
         ST_NORM: begin
            if (stat.b_zero) begin
               ctrl.red_init = !stat.mod_zero;
            end else if (stat.b_top) begin
               ctrl.set_km = stat.first;
            end else begin
               ctrl.norm_dec = 1'b1;
            end
         end
         ST_DIV: begin
            ctrl.div_step = stat.div_go;
            ctrl.swap     = !stat.div_go;
         end
         ST_RED: begin
            ctrl.red_step = stat.red_go;
         end
         ST_DONE: begin
            ctrl.finish = stat.out_free;
         end
         default: ctrl = '0;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      ctrl.start |=> (state_ff == ST_NORM))
      else $error("start did not enter normalization");

   assert property (@(posedge clock) disable iff (reset)
      ctrl.finish |=> ctrl.idle)
      else $error("finish did not return to idle");

   assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl.div_step, ctrl.swap, ctrl.red_step, ctrl.norm_dec, ctrl.finish}))
      else $error("conflicting datapath commands");

endmodule

@@ rtl/core/binary_poly_mod_inverse.sv @@
// ----------------------------------------------------------------------------
// binary_poly_mod_inverse
// Inverse of a binary polynomial modulo a configured binary polynomial.
// ----------------------------------------------------------------------------
// The block inverts operand_poly (bit i = coefficient of x^i) modulo the
// modulus_poly register with the extended Euclidean algorithm over GF(2),
// and returns the reduced Bezout coefficient, the gcd and an invertible flag
// (gcd == 1). One item is processed at a time: req_tready is high only while
// the sequencer is idle. All arithmetic runs on one shared two-lane
// shift-xor unit, one quotient bit per cycle. An item runs a scan to find
// the modulus degree, then per Euclid round a scan over the dividend bits,
// one swap and a renormalization, then a reduction of the coefficient
// modulo the modulus. The short case is a zero modulus (degree scan only);
// the long case is a full-degree modulus where every Euclid round drops
// the remainder degree by one. A zero modulus returns the operand as gcd,
// a zero inverse and a clear flag. The result sits in an output register,
// so a new item is accepted as soon as the finished one has been moved
// there, even while rsp_tready is low.
// ----------------------------------------------------------------------------
module binary_poly_mod_inverse (
   input  logic                                clock,
   input  logic                                reset,
   // input items
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bpmi_pkg::WORD_W-1:0]         req_tdata,   // [63:0] operand_poly
   // result items
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [2*bpmi_pkg::WORD_W-1:0]       rsp_tdata,   // [63:0] inverse_poly,
                                                            // [127:64] gcd_poly
   output logic                                rsp_tuser,   // [0] invertible
   // configuration
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bpmi_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [bpmi_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [bpmi_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import bpmi_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   // configuration register
   logic [WORD_W-1:0] modulus_ff;
   logic              csr_sel_mod;

   // Euclid state: a = old_r, b = r, sa = old_s, sb = s.
   // ka / kb are degree + 1 bounds (kb exact while dividing), km = deg(m) + 1.
   logic [WORD_W-1:0] a_ff, a_in;
   logic [WORD_W-1:0] b_ff, b_in;
   logic [WORD_W-1:0] sa_ff, sa_in;
   logic [WORD_W-1:0] sb_ff, sb_in;
   logic [WORD_W-1:0] mod_ff, mod_in;
   logic [CNT_W-1:0]  ka_ff, ka_in;
   logic [CNT_W-1:0]  kb_ff, kb_in;
   logic [CNT_W-1:0]  km_ff, km_in;
   logic              first_ff, first_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [2*WORD_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;

   logic [SH_W-1:0]   ka_idx;
   logic [SH_W-1:0]   kb_idx;
   logic [SH_W-1:0]   shamt;
   logic [CNT_W-1:0]  sub_k;
   logic [WORD_W-1:0] y1_sel;
   logic [WORD_W-1:0] z0;
   logic [WORD_W-1:0] z1;
   logic              mod_zero;
   logic              gcd_one;

   // ---------------- configuration port ----------------
   assign csr_pready  = 1'b1;
   assign csr_sel_mod = (csr_paddr[3] == REG_MODULUS);
   assign csr_prdata  = csr_sel_mod ? modulus_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_sel_mod) begin
         modulus_ff <= csr_pwdata;
      end
   end

   // ---------------- status to sequencer ----------------
   assign ka_idx   = SH_W'(ka_ff - CNT_W'(1));
   assign kb_idx   = SH_W'(kb_ff - CNT_W'(1));
   assign mod_zero = (mod_ff == '0);
   assign gcd_one  = (a_ff == WORD_W'(1));

   assign req_tready    = ctrl.idle;
   assign stat.req_fire = req_tvalid && req_tready;
   assign stat.b_zero   = (kb_ff == '0);
   assign stat.b_top    = b_ff[kb_idx];
   assign stat.div_go   = (ka_ff >= kb_ff);
   assign stat.mod_zero = mod_zero;
   assign stat.red_go   = (ka_ff >= km_ff);
   assign stat.out_free = !rsp_valid_ff || rsp_tready;
   assign stat.first    = first_ff;

   bpmi_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   // ---------------- shared shift-xor unit ----------------
   // Divide step: a ^= b << (ka-kb), sa ^= sb << (ka-kb).
   // Final reduction: sa ^= m << (ka-km).
   assign sub_k  = ctrl.red_step ? km_ff : kb_ff;
   assign shamt  = SH_W'(ka_ff - sub_k);
   assign y1_sel = ctrl.red_step ? mod_ff : sb_ff;

   bpmi_shift_xor u_sx (
      .x0    (a_ff),
      .y0    (b_ff),
      .x1    (sa_ff),
      .y1    (y1_sel),
      .shamt (shamt),
      .z0    (z0),
      .z1    (z1)
   );

   // ---------------- datapath next values ----------------
   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      sa_in    = sa_ff;
      sb_in    = sb_ff;
      mod_in   = mod_ff;
      ka_in    = ka_ff;
      kb_in    = kb_ff;
      km_in    = km_ff;
      first_in = first_ff;
      if (ctrl.start) begin
         a_in     = req_tdata & POLY_MASK;
         b_in     = modulus_ff & POLY_MASK;
         mod_in   = modulus_ff & POLY_MASK;
         sa_in    = WORD_W'(1);
         sb_in    = '0;
         ka_in    = CNT_W'(POLY_BITS);
         kb_in    = CNT_W'(POLY_BITS);
         first_in = 1'b1;
      end else if (ctrl.norm_dec) begin
         kb_in = kb_ff - CNT_W'(1);
      end else if (ctrl.set_km) begin
         km_in    = kb_ff;
         first_in = 1'b0;
      end else if (ctrl.div_step) begin
         // quotient bit is the dividend bit under the bound
         if (a_ff[ka_idx]) begin
            a_in  = z0;
            sa_in = z1;
         end
         ka_in = ka_ff - CNT_W'(1);
      end else if (ctrl.swap) begin
         a_in  = b_ff;
         b_in  = a_ff;
         sa_in = sb_ff;
         sb_in = sa_ff;
         ka_in = kb_ff;
         kb_in = ka_ff;     // remainder bound, renormalized next
      end else if (ctrl.red_init) begin
         ka_in = CNT_W'(WORD_W);   // coefficient may use all 64 bits
      end else if (ctrl.red_step) begin
         if (sa_ff[ka_idx]) begin
            sa_in = z1;
         end
         ka_in = ka_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      sa_ff    <= sa_in;
      sb_ff    <= sb_in;
      mod_ff   <= mod_in;
      ka_ff    <= ka_in;
      kb_ff    <= kb_in;
      km_ff    <= km_in;
      first_ff <= first_in;
   end

   // ---------------- output register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (ctrl.finish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {a_ff, (mod_zero ? {WORD_W{1'b0}} : sa_ff)};
         rsp_user_in  = gcd_one && !mod_zero;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // ---------------- checks ----------------
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.div_step || ctrl.swap) |-> (kb_ff != '0) && b_ff[kb_idx])
      else $error("divide with divisor not normalized");

   assert property (@(posedge clock) disable iff (reset)
      ctrl.red_step |-> (km_ff != '0) && !mod_zero && mod_ff[SH_W'(km_ff - CNT_W'(1))])
      else $error("reduction with bad modulus degree");

   assert property (@(posedge clock) disable iff (reset)
      ctrl.div_step |-> (ka_ff != '0))
      else $error("divide step with empty dividend bound");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[2*WORD_W-1:WORD_W] == WORD_W'(1)))
      else $error("invertible flag without unit gcd");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the binary polynomial modular inverse block.
// Streams random and corner-case operands under a series of modulus settings.
// Each result is checked against an extended-Euclid predictor over GF(2).
// ----------------------------------------------------------------------------
module tb;

   typedef logic [bpmi_pkg::WORD_W-1:0] poly_type;

   typedef struct packed {
      poly_type inverse_poly;
      poly_type gcd_poly;
      logic     invertible;
   } inverse_result_type;

   // receiver back-pressure patterns
   typedef enum logic [1:0] {
      RX_STREAM,   // always ready
      RX_COIN,     // ready half the time
      RX_SPARSE    // ready one cycle in eight
   } rx_mode_type;

   localparam logic [bpmi_pkg::CSR_ADDR_W-1:0] MODULUS_ADDR =
      {bpmi_pkg::REG_MODULUS, 3'b000};

   localparam int     RANDOM_PHASES   = 12;
   localparam int     ITEMS_PER_PHASE = 134;
   localparam int     HOLD_AT         = 200;     // results seen before the long hold-off
   localparam int     HOLD_CYCLES     = 3000;
   localparam int     DRAIN_CYCLES    = 600;
   localparam longint TIMEOUT_NS      = 40_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   poly_type                            req_tdata  = '0;   // [63:0] operand_poly
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [2*bpmi_pkg::WORD_W-1:0]       rsp_tdata;         // [63:0] inverse_poly,
                                                           // [127:64] gcd_poly
   logic                                rsp_tuser;         // [0] invertible
   logic                                csr_psel    = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite  = 1'b0;
   logic [bpmi_pkg::CSR_ADDR_W-1:0]     csr_paddr   = '0;
   logic [bpmi_pkg::CSR_DATA_W-1:0]     csr_pwdata  = '0;
   logic [bpmi_pkg::CSR_DATA_W-1:0]     csr_prdata;
   logic                                csr_pready;

   binary_poly_mod_inverse dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Bench state
   // ---------------------------------------------------------------------
   poly_type           pending_operands[$];     // operands not yet offered
   inverse_result_type expected_inverses[$];    // predictions awaiting a result
   poly_type           modulus_copy   = '0;     // bench copy of the modulus register
   int unsigned        items_queued   = 0;
   int unsigned        items_accepted = 0;
   int unsigned        results_seen   = 0;
   int unsigned        fault_count    = 0;
   logic               req_fire       = 1'b0;   // input item taken at the last rising edge

   // ---------------------------------------------------------------------
   // GF(2) polynomial predictor
   // ---------------------------------------------------------------------
   // degree of p, -1 for the zero polynomial
   function automatic int poly_degree(input poly_type p);
      for (int i = bpmi_pkg::WORD_W - 1; i >= 0; i--)
         if (p[i]) return i;
      return -1;
   endfunction

   // carry-less product, truncated to the word
   function automatic poly_type clmul(input poly_type a, input poly_type b);
      poly_type acc;
      acc = '0;
      for (int i = 0; i < bpmi_pkg::WORD_W; i++)
         if (a[i]) acc ^= b << i;
      return acc;
   endfunction

   // carry-less long division, divisor nonzero
   function automatic void gf2_divmod(input poly_type n, input poly_type d,
                                      output poly_type q, output poly_type r);
      int dd;
      int rd;
      dd = poly_degree(d);
      rd = poly_degree(n);
      q  = '0;
      while (rd >= dd) begin
         q  |= poly_type'(1) << (rd - dd);
         n  ^= d << (rd - dd);
         rd  = poly_degree(n);
      end
      r = n;
   endfunction

   // extended Euclid on (operand, modulus); Bezout coefficient of operand
   function automatic inverse_result_type predict_inverse(input poly_type operand,
                                                          input poly_type modulus);
      poly_type m, old_r, r, old_s, s, q, rem, nxt;
      inverse_result_type res;
      m     = modulus & bpmi_pkg::POLY_MASK;
      old_r = operand & bpmi_pkg::POLY_MASK;
      r     = m;
      old_s = poly_type'(1);
      s     = '0;
      while (r != '0) begin
         gf2_divmod(old_r, r, q, rem);
         old_r = r;
         r     = rem;
         nxt   = clmul(q, s) ^ old_s;
         old_s = s;
         s     = nxt;
      end
      res.gcd_poly = old_r;
      if (m == '0) begin
         // gcd(a, 0) = a, nothing to invert against
         res.inverse_poly = '0;
         res.invertible   = 1'b0;
      end else begin
         gf2_divmod(old_s, m, q, rem);
         res.inverse_poly = rem;
         res.invertible   = (old_r == poly_type'(1));
      end
      return res;
   endfunction

   // operand mix: full width, random degree, tiny, sparse, products with a
   // small factor, and near the modulus itself
   function automatic poly_type random_poly(input poly_type modulus);
      poly_type full;
      full = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0, 1: return full;
         2:    return full >> $urandom_range(1, 63);
         3:    return poly_type'($urandom_range(0, 15));
         4:    return (poly_type'(1) << $urandom_range(0, 63)) ^
                      (poly_type'(1) << $urandom_range(0, 63));
         5:    return clmul(poly_type'($urandom_range(1, 255)),
                            full >> $urandom_range(8, 63));
         6:    return modulus ^ poly_type'($urandom_range(0, 3));
         default: return full >> $urandom_range(0, 8);
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic queue_operand(input poly_type operand);
      pending_operands.push_back(operand);
      items_queued++;
   endtask

   // block is idle once every queued item is in and every result is out
   task automatic wait_idle();
      while (items_accepted != items_queued || expected_inverses.size() != 0)
         @(negedge clock);
   endtask

   // APB write of the modulus, then a read back checked by the monitor
   task automatic write_modulus(input poly_type value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= MODULUS_ADDR;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      modulus_copy = value;
      @(negedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic new_phase(input poly_type modulus);
      wait_idle();
      write_modulus(modulus);
   endtask

   // ---------------------------------------------------------------------
   // Sequence: reset, directed corners, then random phases
   // ---------------------------------------------------------------------
   initial begin
      poly_type mod_list[RANDOM_PHASES];
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero modulus: gcd is the operand, flag clear
      new_phase('0);
      queue_operand('0);
      queue_operand(poly_type'(1));
      queue_operand('1);
      queue_operand(64'h8000_0000_0000_0000);
      queue_operand(64'h0123_4567_89ab_cdef);

      // modulus one: everything invertible, inverse reduces to zero
      new_phase(poly_type'(1));
      queue_operand('0);
      queue_operand(poly_type'(1));
      queue_operand('1);

      // degree-8 irreducible: zero operand, equal, multiple, higher degree
      new_phase(64'h11b);
      queue_operand('0);
      queue_operand(poly_type'(1));
      queue_operand(poly_type'(2));
      queue_operand(64'h53);
      queue_operand(64'h11b);
      queue_operand(64'h11b << 3);
      queue_operand('1);
      queue_operand(64'h8000_0000_0000_0000);
      queue_operand(64'h3);

      // all-ones modulus, full-degree operands
      new_phase('1);
      queue_operand(poly_type'(1));
      queue_operand('1);
      queue_operand(64'h8000_0000_0000_0000);
      queue_operand(64'h5555_5555_5555_5555);

      // degree-63 trinomial
      new_phase(64'h8000_0000_0000_0003);
      queue_operand(poly_type'(1));
      queue_operand(64'haaaa_aaaa_aaaa_aaaa);
      queue_operand(64'h8000_0000_0000_0003);

      // random part: extremes first, then random moduli of mixed degree
      mod_list[0] = '0;
      mod_list[1] = poly_type'(1);
      mod_list[2] = poly_type'(2);
      mod_list[3] = poly_type'(7);
      mod_list[4] = '1;
      mod_list[5] = 64'h8000_0000_0000_0000;
      mod_list[6] = 64'h8000_0000_0000_001b;
      for (int i = 7; i < RANDOM_PHASES; i++)
         mod_list[i] = (i % 2 == 0) ? ({$urandom, $urandom} | 64'h8000_0000_0000_0000)
                                    : ({$urandom, $urandom} >> $urandom_range(1, 56));

      foreach (mod_list[p]) begin
         new_phase(mod_list[p]);
         repeat (ITEMS_PER_PHASE) queue_operand(random_poly(mod_list[p]));
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_inverses.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_inverses.size());
         fault_count++;
      end
      if (fault_count == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tb NOT OK");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Driver: bursts of items separated by random gaps
   // ---------------------------------------------------------------------
   int unsigned burst_left = 1;
   int unsigned gap_left   = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         // slot is free: current item was taken or none offered
         if (gap_left != 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_operands.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_operands.pop_front();
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 48);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: stall pattern that switches periodically to a random mode, plus one long
   // hold-off so the output register and the core both fill up
   // ---------------------------------------------------------------------
   rx_mode_type rx_mode   = RX_STREAM;
   int unsigned mode_left = 0;
   int unsigned hold_left = 0;
   logic        hold_done = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            rx_mode   <= rx_mode_type'($urandom_range(0, 2));
            mode_left <= 128;
         end else begin
            mode_left <= mode_left - 1;
         end
         case (rx_mode)
            RX_STREAM: rsp_tready <= 1'b1;
            RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            default:   rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predict on input accept, check on result accept, check reads
   // ---------------------------------------------------------------------
   task automatic check_field(input string name, input poly_type want, input poly_type got);
      if (want !== got) begin
         $display("%0t: %s expected %h got %h", $time, name, want, got);
         fault_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      inverse_result_type got;
      inverse_result_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;

         // results first: a result always belongs to an older item
         if (rsp_tvalid && rsp_tready) begin
            got.inverse_poly = rsp_tdata[bpmi_pkg::WORD_W-1:0];
            got.gcd_poly     = rsp_tdata[2*bpmi_pkg::WORD_W-1:bpmi_pkg::WORD_W];
            got.invertible   = rsp_tuser;
            results_seen++;
            if (expected_inverses.size() == 0) begin
               $display("%0t: unexpected result inverse %h gcd %h flag %b",
                        $time, got.inverse_poly, got.gcd_poly, got.invertible);
               fault_count++;
            end else begin
               want = expected_inverses.pop_front();
               check_field("inverse_poly", want.inverse_poly, got.inverse_poly);
               check_field("gcd_poly", want.gcd_poly, got.gcd_poly);
               check_field("invertible", poly_type'(want.invertible),
                           poly_type'(got.invertible));
            end
         end

         if (req_tvalid && req_tready) begin
            expected_inverses.push_back(predict_inverse(req_tdata, modulus_copy));
            items_accepted++;
         end

         if (csr_psel && csr_penable && !csr_pwrite && csr_pready)
            check_field("modulus_poly readback", modulus_copy, csr_prdata);
      end
   end

endmodule
